[design/oriented_full_angle_about_normal_unit_assert.svh]
// ----------------------------------------------------------------------------
// Oriented angle unit assertion macros
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_FULL_ANGLE_ABOUT_NORMAL_UNIT_ASSERT_SVH
`define ORIENTED_FULL_ANGLE_ABOUT_NORMAL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define OFA_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define OFA_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define OFA_ASSERT(label, clock, reset, prop, msg)
`define OFA_ASSERT_ALWAYS(label, clock, prop, msg)
`endif
`endif

[design/ofa_pkg.sv]
// ----------------------------------------------------------------------------
// Oriented angle unit package
// Default parameters, internal widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package ofa_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Q2.14 working coordinate width
  localparam int QW14 = 16;
  // dot product with the normal, Q7.28
  localparam int DW   = 35;
  // unscaled projection, Q.42
  localparam int PW   = 52;
  // width of the leading-one position
  localparam int LW   = 6;
  // block-scaled projection: magnitude below 2^20 plus sign
  localparam int NORM_BITS = 20;
  localparam int SW   = NORM_BITS + 1;
  // cross product component
  localparam int CW   = 38;
  // cross product times projection
  localparam int SPW  = CW + SW;
  // projection times projection
  localparam int CPW  = 2 * SW;
  // CORDIC datapath
  localparam int XW   = 64;
  localparam int ZW   = 32;

  // Angle of atan(2^-i) in units of 2^-32 turn
  function automatic logic [ZW-1:0] atan_turn(input logic [4:0] idx);
    logic [ZW-1:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[design/oriented_full_angle_about_normal_unit.sv]
// Throughput: one request per cycle; every stage is a register that advances
// together, and the whole pipe holds only while a result waits on out_stall.
// Reset (rst, synchronous) clears all stage valid bits; datapath is not reset.
// ----------------------------------------------------------------------------
// Oriented full angle about a normal
// Projects two vectors into the tangent plane of a normal and returns the
// counter-clockwise angle between them as a fraction of a turn (CORDIC).
// ----------------------------------------------------------------------------
`default_nettype none
`include "oriented_full_angle_about_normal_unit_assert.svh"
module oriented_full_angle_about_normal_unit #(
  parameter int COORD_WIDTH   = ofa_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ofa_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = ofa_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [COORD_WIDTH-1:0] normal_x,
  input  logic signed [COORD_WIDTH-1:0] normal_y,
  input  logic signed [COORD_WIDTH-1:0] normal_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_WIDTH-1:0]        turn_angle,
  output logic                          degenerate
);

  localparam int QW  = ofa_pkg::QW14;
  localparam int DW  = ofa_pkg::DW;
  localparam int PW  = ofa_pkg::PW;
  localparam int LW  = ofa_pkg::LW;
  localparam int SW  = ofa_pkg::SW;
  localparam int CW  = ofa_pkg::CW;
  localparam int SPW = ofa_pkg::SPW;
  localparam int CPW = ofa_pkg::CPW;
  localparam int XW  = ofa_pkg::XW;
  localparam int ZW  = ofa_pkg::ZW;
  localparam int NB  = ofa_pkg::NORM_BITS;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Bring inputs to Q2.14
  logic signed [COORD_WIDTH-1:0] raw [9];
  logic signed [QW-1:0]          cq  [9];
  assign raw = '{first_x, first_y, first_z, second_x, second_y, second_z,
                 normal_x, normal_y, normal_z};
  for (genvar k = 0; k < 9; k++) begin : g_q14
    if (COORD_WIDTH > QW) begin : g_dn
      assign cq[k] = QW'(raw[k] >>> (COORD_WIDTH - QW));
    end else if (COORD_WIDTH < QW) begin : g_up
      assign cq[k] = {raw[k], {(QW - COORD_WIDTH){1'b0}}};
    end else begin : g_eq
      assign cq[k] = raw[k];
    end
  end

  // Stage 1: dot products with the normal
  logic                 v1;
  logic signed [QW-1:0] a1 [3], b1 [3], n1 [3];
  logic signed [DW-1:0] da1, db1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] <= cq[i];
        b1[i] <= cq[3 + i];
        n1[i] <= cq[6 + i];
      end
      da1 <= DW'(cq[0] * cq[6]) + DW'(cq[1] * cq[7]) + DW'(cq[2] * cq[8]);
      db1 <= DW'(cq[3] * cq[6]) + DW'(cq[4] * cq[7]) + DW'(cq[5] * cq[8]);
    end
  end

  // Stage 2: subtract the normal part
  logic                 v2;
  logic signed [PW-1:0] pa2 [3], pb2 [3];
  logic signed [QW-1:0] n2 [3];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa2[i] <= (PW'(a1[i]) <<< 28) - PW'(n1[i] * da1);
        pb2[i] <= (PW'(b1[i]) <<< 28) - PW'(n1[i] * db1);
        n2[i]  <= n1[i];
      end
    end
  end

  // Stage 3: OR of magnitudes, whose top bit matches that of the largest
  logic                 v3;
  logic signed [PW-1:0] pa3 [3], pb3 [3];
  logic signed [QW-1:0] n3 [3];
  logic [PW-1:0]        ma3, mb3;
  logic [PW-1:0]        ma_c, mb_c;
  always_comb begin
    ma_c = '0;
    mb_c = '0;
    for (int i = 0; i < 3; i++) begin
      ma_c = ma_c | (pa2[i][PW-1] ? PW'(-pa2[i]) : PW'(pa2[i]));
      mb_c = mb_c | (pb2[i][PW-1] ? PW'(-pb2[i]) : PW'(pb2[i]));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pa3 <= pa2;
      pb3 <= pb2;
      n3  <= n2;
      ma3 <= ma_c;
      mb3 <= mb_c;
    end
  end

  // Stage 4: leading-one position
  logic                 v4, dg4;
  logic signed [PW-1:0] pa4 [3], pb4 [3];
  logic signed [QW-1:0] n4 [3];
  logic [LW-1:0]        la4, lb4;
  logic [LW-1:0]        la_c, lb_c;
  always_comb begin
    la_c = '0;
    lb_c = '0;
    for (int k = 0; k < PW; k++) begin
      if (ma3[k]) la_c = LW'(k + 1);
      if (mb3[k]) lb_c = LW'(k + 1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pa4 <= pa3;
      pb4 <= pb3;
      n4  <= n3;
      la4 <= la_c;
      lb4 <= lb_c;
      dg4 <= (ma3 == '0) || (mb3 == '0);
    end
  end

  // Stage 5: block scale so the largest magnitude lies in [2^19, 2^20)
  logic                 v5, dg5;
  logic signed [SW-1:0] qa5 [3], qb5 [3];
  logic signed [QW-1:0] n5 [3];
  logic signed [PW-1:0] sa_c [3], sb_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (la4 > LW'(NB)) sa_c[i] = pa4[i] >>> (la4 - LW'(NB));
      else sa_c[i] = pa4[i] <<< (LW'(NB) - la4);
      if (lb4 > LW'(NB)) sb_c[i] = pb4[i] >>> (lb4 - LW'(NB));
      else sb_c[i] = pb4[i] <<< (LW'(NB) - lb4);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qa5[i] <= sa_c[i][SW-1:0];
        qb5[i] <= sb_c[i][SW-1:0];
      end
      n5  <= n4;
      dg5 <= dg4;
    end
  end

  // Stage 6: cross product n x p1 and cosine partial products
  logic                  v6, dg6;
  logic signed [CW-1:0]  c6 [3];
  logic signed [CPW-1:0] cp6 [3];
  logic signed [SW-1:0]  qb6 [3];
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c6[0] <= CW'(n5[1] * qa5[2]) - CW'(n5[2] * qa5[1]);
      c6[1] <= CW'(n5[2] * qa5[0]) - CW'(n5[0] * qa5[2]);
      c6[2] <= CW'(n5[0] * qa5[1]) - CW'(n5[1] * qa5[0]);
      for (int i = 0; i < 3; i++) cp6[i] <= CPW'(qa5[i] * qb5[i]);
      qb6 <= qb5;
      dg6 <= dg5;
    end
  end

  // Stage 7: side partial products and cosine sum
  logic                  v7, dg7;
  logic signed [SPW-1:0] sp7 [3];
  logic signed [XW-1:0]  cs7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sp7[i] <= SPW'(c6[i] * qb6[i]);
      cs7 <= XW'(cp6[0]) + XW'(cp6[1]) + XW'(cp6[2]);
      dg7 <= dg6;
    end
  end

  // Stage 8: side sum, scale cosine, turn by half a turn when X < 0
  logic signed [XW-1:0] cx [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1];
  logic [ZW-1:0]        cz [CORDIC_STAGES+1];
  logic                 cv [CORDIC_STAGES+1];
  logic                 cd [CORDIC_STAGES+1];
  logic signed [XW-1:0] xs_c, ys_c;
  assign xs_c = cs7 <<< 14;
  assign ys_c = XW'(sp7[0]) + XW'(sp7[1]) + XW'(sp7[2]);
  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (en) cv[0] <= v7;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cx[0] <= xs_c[XW-1] ? -xs_c : xs_c;
      cy[0] <= xs_c[XW-1] ? -ys_c : ys_c;
      cz[0] <= xs_c[XW-1] ? {1'b1, {(ZW-1){1'b0}}} : '0;
      cd[0] <= dg7;
    end
  end

  // CORDIC vectoring stages, one register each
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cordic
    logic          up;
    logic [ZW-1:0] at;
    assign up = !cy[s][XW-1] && (cy[s] != '0);
    assign at = ofa_pkg::atan_turn(5'(s));
    always_ff @(posedge clk) begin
      if (rst) cv[s+1] <= 1'b0;
      else if (en) cv[s+1] <= cv[s];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (up) begin
          cx[s+1] <= cx[s] + (cy[s] >>> s);
          cy[s+1] <= cy[s] - (cx[s] >>> s);
          cz[s+1] <= cz[s] + at;
        end else begin
          cx[s+1] <= cx[s] - (cy[s] >>> s);
          cy[s+1] <= cy[s] + (cx[s] >>> s);
          cz[s+1] <= cz[s] - at;
        end
        cd[s+1] <= cd[s];
      end
    end
  end

  // Output stage: round to the angle width, force zero when degenerate
  logic [ANGLE_WIDTH-1:0] ang_c;
  logic [ZW-1:0]          zf;
  assign zf = cz[CORDIC_STAGES];
  if (ANGLE_WIDTH < ZW) begin : g_round
    logic [ZW-1:0] zr;
    assign zr    = zf + (ZW'(1) << (ZW - 1 - ANGLE_WIDTH));
    assign ang_c = zr[ZW-1 -: ANGLE_WIDTH];
  end else begin : g_full
    assign ang_c = zf[ANGLE_WIDTH-1:0];
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= cv[CORDIC_STAGES];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      turn_angle <= cd[CORDIC_STAGES] ? '0 : ang_c;
      degenerate <= cd[CORDIC_STAGES];
    end
  end

  `OFA_ASSERT(a_deg_zero, clk, rst, out_valid && degenerate |-> turn_angle == '0, "degenerate result with nonzero angle")
  `OFA_ASSERT(a_enter, clk, rst, in_valid && !in_stall |=> v1, "accepted request lost at stage one")
  `OFA_ASSERT(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(degenerate), "held result dropped")
  `OFA_ASSERT(a_advance, clk, rst, v4 && en |=> v5, "pipeline valid lost in scaling stage")

endmodule
`default_nettype wire
